// ----- rtl/pulse_width_frame_decoder_core_assert.svh -----
// Assertion macros for the pulse-width frame decoder.
// Included by the top level; needs nothing else.
`ifndef PULSE_WIDTH_FRAME_DECODER_CORE_ASSERT_SVH
`define PULSE_WIDTH_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define PWFD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PWFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pwfd_pkg.sv -----
// Shared types, constants and the CRC-8 byte step for the pulse-width frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package pwfd_pkg;

    localparam int INTERVAL_W = 20;
    localparam int COUNT_W    = 32;
    localparam int EV_W       = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 168;
    localparam int CFG_COUNT  = 8;
    localparam int PADDR_W    = 5;

    // register indexes
    localparam logic [2:0] CFG_START_MIN = 3'd0;
    localparam logic [2:0] CFG_START_MAX = 3'd1;
    localparam logic [2:0] CFG_STOP_MIN  = 3'd2;
    localparam logic [2:0] CFG_STOP_MAX  = 3'd3;
    localparam logic [2:0] CFG_ZERO_MIN  = 3'd4;
    localparam logic [2:0] CFG_ZERO_MAX  = 3'd5;
    localparam logic [2:0] CFG_ONE_MIN   = 3'd6;
    localparam logic [2:0] CFG_ONE_MAX   = 3'd7;

    localparam logic [7:0] HEADER_CHAR  = 8'h24;  // '$'
    localparam logic [7:0] TRAILER_CHAR = 8'h23;  // '#'
    localparam logic [7:0] CRC_XOR      = 8'h18;
    localparam logic [7:0] CRC_TOP      = 8'h80;
    localparam logic [7:0] CRC_KEEP     = 8'h7F;

    typedef enum logic [EV_W-1:0] {
        EV_NONE,
        EV_OK,
        EV_LENGTH,
        EV_HEADER,
        EV_CRC,
        EV_TIMING
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MODIFY,
        ST_CRC,
        ST_JUDGE,
        ST_EMIT
    } state_t;

    function automatic logic in_win(input logic [INTERVAL_W-1:0] v,
                                    input logic [INTERVAL_W-1:0] lo,
                                    input logic [INTERVAL_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Dallas/Maxim CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc_in;
        d = data_in;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[0];
            if (fb) begin
                c = c ^ CRC_XOR;
            end
            c = (c >> 1) & CRC_KEEP;
            if (fb) begin
                c = c | CRC_TOP;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

// ----- rtl/pwfd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pwfd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pulse_width_frame_decoder_core.sv -----
// Top level of the pulse-width frame decoder: control FSM, counters, APB registers.
// Depends on pwfd_pkg, pwfd_ram and pulse_width_frame_decoder_core_assert.svh.
`timescale 1ns / 1ps
`include "pulse_width_frame_decoder_core_assert.svh"

// Pulse-width frame decoder. Each input word is one line edge (level and the
// microseconds since the previous edge); each produces exactly one result word
// with an event code and the five running counters. High-level edges are sorted
// by the start, stop, zero and one windows (tried in that order, limits
// inclusive, an empty window never matches). Data bits land LSB first in a
// FRAME_BYTES-deep frame store RAM; a stop checks length, '$' header, '#'
// trailer and the Dallas CRC-8. Throughput is one word at a time: low-level,
// start, out-of-frame, timing-error and length-error words go straight to emit;
// a data bit adds a modify step (read-modify-write of the store byte); any
// other stop adds a CRC walk, reading one store byte per cycle over the RAM's
// single read port, and a judge step. A new word is taken while the previous
// result still waits on m_tready. Store restarts are instant (per-entry valid
// flops), so there is no clearing pass after reset. Config registers sit at
// byte address 4*i and should be written only while the block is idle.
module pulse_width_frame_decoder_core #(
    parameter int FRAME_BYTES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [0] level, [20:1] interval_us, [23:21] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pwfd_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [2:0] event_res, [34:3] frame_count, [66:35] timing_errors,
    //          [98:67] length_errors, [130:99] header_errors,
    //          [162:131] crc_errors, [167:163] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pwfd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pwfd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    import pwfd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0] CRC_IDX  = AW'(FRAME_BYTES - 2);

    // ---------------- configuration registers ----------------
    logic [INTERVAL_W-1:0] cfg_reg [CFG_COUNT];
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {{(32 - INTERVAL_W){1'b0}}, cfg_reg[paddr[4:2]]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            cfg_reg[paddr[4:2]] <= pwdata[INTERVAL_W-1:0];
        end
    end

    // ---------------- state ----------------
    state_t                state_reg, state_next;
    logic [2:0]            bit_idx_reg, bit_idx_next;
    logic [AW-1:0]         byte_idx_reg, byte_idx_next;
    logic                  in_frame_reg, in_frame_next;
    logic [FRAME_BYTES-1:0] valid_reg, valid_next;   // store entry written since restart
    logic [COUNT_W-1:0]    good_reg, timing_reg, length_reg, header_reg, crc_cnt_reg;
    logic                  inc_good, inc_timing, inc_length, inc_header, inc_crc;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  walk_issue_reg, walk_issue_next;
    logic                  proc_vld_reg, proc_vld_next;

    // payload
    logic                  level_reg, level_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    event_t                ev_reg, ev_next;
    logic                  bitval_reg, bitval_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [AW-1:0]         walk_addr_reg, walk_addr_next;
    logic [AW-1:0]         proc_idx_reg, proc_idx_next;
    logic [7:0]            crc_reg, crc_next;
    logic [7:0]            exp_reg, exp_next;
    logic                  hdr_ok_reg, hdr_ok_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // RAM port
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [7:0]            ram_wdata, ram_rdata;

    logic                  hit_start, hit_stop, hit_zero, hit_one;
    logic [7:0]            rd_byte;
    logic [7:0]            new_byte;

    pwfd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES),
        .ADDR_W(AW)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign hit_start = in_win(interval_reg, cfg_reg[CFG_START_MIN], cfg_reg[CFG_START_MAX]);
    assign hit_stop  = in_win(interval_reg, cfg_reg[CFG_STOP_MIN],  cfg_reg[CFG_STOP_MAX]);
    assign hit_zero  = in_win(interval_reg, cfg_reg[CFG_ZERO_MIN],  cfg_reg[CFG_ZERO_MAX]);
    assign hit_one   = in_win(interval_reg, cfg_reg[CFG_ONE_MIN],   cfg_reg[CFG_ONE_MAX]);

    // an entry not written since the last restart reads as zero
    assign rd_byte = rd_valid_reg ? ram_rdata : 8'h00;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        bit_idx_next    = bit_idx_reg;
        byte_idx_next   = byte_idx_reg;
        in_frame_next   = in_frame_reg;
        valid_next      = valid_reg;
        walk_issue_next = walk_issue_reg;
        proc_vld_next   = 1'b0;
        level_next      = level_reg;
        interval_next   = interval_reg;
        ev_next         = ev_reg;
        bitval_next     = bitval_reg;
        rd_valid_next   = rd_valid_reg;
        walk_addr_next  = walk_addr_reg;
        proc_idx_next   = proc_idx_reg;
        crc_next        = crc_reg;
        exp_next        = exp_reg;
        hdr_ok_next     = hdr_ok_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        inc_good        = 1'b0;
        inc_timing      = 1'b0;
        inc_length      = 1'b0;
        inc_header      = 1'b0;
        inc_crc         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = byte_idx_reg;
        ram_wdata       = 8'h00;
        ram_re          = 1'b0;
        ram_raddr       = byte_idx_reg;
        new_byte        = rd_byte;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    level_next    = s_tdata[0];
                    interval_next = s_tdata[INTERVAL_W:1];
                    state_next    = ST_DECODE;
                end
            end

            ST_DECODE: begin
                ev_next    = EV_NONE;
                state_next = ST_EMIT;
                if (level_reg) begin
                    if (hit_start) begin
                        if (bit_idx_reg != 3'd0 || byte_idx_reg != '0) begin
                            inc_length = 1'b1;
                            ev_next    = EV_LENGTH;
                        end
                        bit_idx_next  = 3'd0;
                        byte_idx_next = '0;
                        valid_next    = '0;
                        in_frame_next = 1'b1;
                    end else if (in_frame_reg) begin
                        if (hit_stop) begin
                            if (byte_idx_reg != '0) begin
                                inc_length    = 1'b1;
                                ev_next       = EV_LENGTH;
                                bit_idx_next  = 3'd0;
                                byte_idx_next = '0;
                                valid_next    = '0;
                                in_frame_next = 1'b0;
                            end else begin
                                walk_addr_next  = '0;
                                walk_issue_next = 1'b1;
                                crc_next        = 8'h00;
                                hdr_ok_next     = 1'b1;
                                state_next      = ST_CRC;
                            end
                        end else if (hit_zero || hit_one) begin
                            ram_re        = 1'b1;
                            ram_raddr     = byte_idx_reg;
                            rd_valid_next = valid_reg[byte_idx_reg];
                            bitval_next   = !hit_zero;
                            state_next    = ST_MODIFY;
                        end else begin
                            inc_timing    = 1'b1;
                            ev_next       = EV_TIMING;
                            bit_idx_next  = 3'd0;
                            byte_idx_next = '0;
                            valid_next    = '0;
                            in_frame_next = 1'b0;
                        end
                    end
                end
            end

            ST_MODIFY: begin
                new_byte[bit_idx_reg]   = bitval_reg;
                ram_we                  = 1'b1;
                ram_waddr               = byte_idx_reg;
                ram_wdata               = new_byte;
                valid_next[byte_idx_reg] = 1'b1;
                bit_idx_next            = bit_idx_reg + 3'd1;
                if (bit_idx_reg == 3'd7) begin
                    byte_idx_next = (byte_idx_reg == LAST_IDX) ? '0 : byte_idx_reg + 1'b1;
                end
                state_next = ST_EMIT;
            end

            ST_CRC: begin
                // issue side: one read per cycle
                if (walk_issue_reg) begin
                    ram_re        = 1'b1;
                    ram_raddr     = walk_addr_reg;
                    rd_valid_next = valid_reg[walk_addr_reg];
                    proc_vld_next = 1'b1;
                    proc_idx_next = walk_addr_reg;
                    if (walk_addr_reg == LAST_IDX) begin
                        walk_issue_next = 1'b0;
                    end else begin
                        walk_addr_next = walk_addr_reg + 1'b1;
                    end
                end
                // data side: byte read in the previous cycle
                if (proc_vld_reg) begin
                    if (proc_idx_reg == '0 && rd_byte != HEADER_CHAR) begin
                        hdr_ok_next = 1'b0;
                    end
                    if (proc_idx_reg == LAST_IDX && rd_byte != TRAILER_CHAR) begin
                        hdr_ok_next = 1'b0;
                    end
                    if (proc_idx_reg < CRC_IDX) begin
                        crc_next = crc8_byte(crc_reg, rd_byte);
                    end
                    if (proc_idx_reg == CRC_IDX) begin
                        exp_next = rd_byte;
                    end
                    if (proc_idx_reg == LAST_IDX) begin
                        state_next = ST_JUDGE;
                    end
                end
            end

            ST_JUDGE: begin
                if (!hdr_ok_reg) begin
                    inc_header = 1'b1;
                    ev_next    = EV_HEADER;
                end else if (crc_reg != exp_reg) begin
                    inc_crc = 1'b1;
                    ev_next = EV_CRC;
                end else begin
                    inc_good = 1'b1;
                    ev_next  = EV_OK;
                end
                bit_idx_next  = 3'd0;
                byte_idx_next = '0;
                valid_next    = '0;
                in_frame_next = 1'b0;
                state_next    = ST_EMIT;
            end

            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - EV_W - 5 * COUNT_W){1'b0}},
                                     crc_cnt_reg, header_reg, length_reg,
                                     timing_reg, good_reg, ev_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bit_idx_reg    <= 3'd0;
            byte_idx_reg   <= '0;
            in_frame_reg   <= 1'b0;
            valid_reg      <= '0;
            good_reg       <= '0;
            timing_reg     <= '0;
            length_reg     <= '0;
            header_reg     <= '0;
            crc_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            walk_issue_reg <= 1'b0;
            proc_vld_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            bit_idx_reg    <= bit_idx_next;
            byte_idx_reg   <= byte_idx_next;
            in_frame_reg   <= in_frame_next;
            valid_reg      <= valid_next;
            good_reg       <= good_reg + COUNT_W'(inc_good);
            timing_reg     <= timing_reg + COUNT_W'(inc_timing);
            length_reg     <= length_reg + COUNT_W'(inc_length);
            header_reg     <= header_reg + COUNT_W'(inc_header);
            crc_cnt_reg    <= crc_cnt_reg + COUNT_W'(inc_crc);
            m_tvalid_reg   <= m_tvalid_next;
            walk_issue_reg <= walk_issue_next;
            proc_vld_reg   <= proc_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg     <= level_next;
        interval_reg  <= interval_next;
        ev_reg        <= ev_next;
        bitval_reg    <= bitval_next;
        rd_valid_reg  <= rd_valid_next;
        walk_addr_reg <= walk_addr_next;
        proc_idx_reg  <= proc_idx_next;
        crc_reg       <= crc_next;
        exp_reg       <= exp_next;
        hdr_ok_reg    <= hdr_ok_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // ---------------- assertions ----------------
    // store is only written back in the modify step, never during the CRC walk
    `PWFD_ASSERT_SAME(a_store_write_in_modify, aclk, aresetn, ram_we, state_reg == ST_MODIFY, "frame store written outside modify step")
    // a judged frame always leaves the decoder restarted
    `PWFD_ASSERT_NEXT(a_judge_restarts, aclk, aresetn, state_reg == ST_JUDGE, !in_frame_reg && bit_idx_reg == 3'd0 && byte_idx_reg == '0 && valid_reg == '0, "frame not restarted after judge")
    // at most one counter moves per cycle
    `PWFD_ASSERT_SAME(a_one_count_step, aclk, aresetn, 1'b1, $onehot0({inc_good, inc_timing, inc_length, inc_header, inc_crc}), "more than one counter stepped")

endmodule

// ----- test/pwfd_checker.sv -----
// Scoreboard for the pulse-width frame decoder: watches the edge and result streams.
// Keeps its own decoder state, predicts each result word and compares it field by field.
// Depends on pwfd_pkg for field widths, register indexes and event codes.
`timescale 1ns / 1ps

module pwfd_checker
    import pwfd_pkg::*;
#(
    parameter int FRAME_BYTES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output int                   fail_count,
    output int                   outstanding,
    output int                   words_checked,
    output int                   frames_good
);

    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    typedef struct packed {
        event_t             ev;
        logic [COUNT_W-1:0] good;
        logic [COUNT_W-1:0] timing;
        logic [COUNT_W-1:0] length;
        logic [COUNT_W-1:0] header;
        logic [COUNT_W-1:0] crc;
    } decode_result_t;

    // shadow of the window registers and the decoder state
    logic [INTERVAL_W-1:0] win [CFG_COUNT];
    logic [7:0]            frame_buf [FRAME_BYTES];
    logic [2:0]            bit_pos;
    int                    byte_pos;
    logic                  frame_open;
    logic [COUNT_W-1:0]    n_good, n_timing, n_length, n_header, n_crc;

    decode_result_t        result_q [$];
    int                    fails;

    function automatic bit hit(input logic [INTERVAL_W-1:0] v, input logic [2:0] lo_idx);
        return (v >= win[lo_idx]) && (v <= win[lo_idx + 3'd1]);
    endfunction

    task automatic clear_frame();
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_buf[i] = 8'h00;
        end
        bit_pos    = 3'd0;
        byte_pos   = 0;
        frame_open = 1'b0;
    endtask

    // reflected CRC-8 over everything but the CRC byte and the trailer
    function automatic logic [7:0] frame_crc8();
        logic [7:0] c;
        logic [7:0] d;
        c = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 2; i++) begin
            d = frame_buf[i];
            for (int k = 0; k < 8; k++) begin
                c = (c[0] ^ d[0]) ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
                d = d >> 1;
            end
        end
        return c;
    endfunction

    task automatic put_bit(input logic b);
        frame_buf[byte_pos][bit_pos] = b;
        if (bit_pos == 3'd7) begin
            byte_pos = (byte_pos == FRAME_BYTES - 1) ? 0 : byte_pos + 1;
        end
        bit_pos = bit_pos + 3'd1;
    endtask

    task automatic decode_edge(input logic lvl, input logic [INTERVAL_W-1:0] iv,
                               output decode_result_t r);
        event_t ev;
        ev = EV_NONE;
        if (lvl) begin
            if (hit(iv, CFG_START_MIN)) begin
                if (bit_pos != 3'd0 || byte_pos != 0) begin
                    n_length++;
                    ev = EV_LENGTH;
                end
                clear_frame();
                frame_open = 1'b1;
            end else if (frame_open) begin
                if (hit(iv, CFG_STOP_MIN)) begin
                    if (byte_pos != 0) begin
                        n_length++;
                        ev = EV_LENGTH;
                    end else if (frame_buf[0] != HEADER_CHAR ||
                                 frame_buf[FRAME_BYTES-1] != TRAILER_CHAR) begin
                        n_header++;
                        ev = EV_HEADER;
                    end else if (frame_crc8() != frame_buf[FRAME_BYTES-2]) begin
                        n_crc++;
                        ev = EV_CRC;
                    end else begin
                        n_good++;
                        ev = EV_OK;
                    end
                    clear_frame();
                end else if (hit(iv, CFG_ZERO_MIN)) begin
                    put_bit(1'b0);
                end else if (hit(iv, CFG_ONE_MIN)) begin
                    put_bit(1'b1);
                end else begin
                    n_timing++;
                    ev = EV_TIMING;
                    clear_frame();
                end
            end
        end
        r = '{ev, n_good, n_timing, n_length, n_header, n_crc};
    endtask

    task automatic compare_field(input string name, input logic [COUNT_W-1:0] exp_v,
                                 input logic [COUNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: result word %0d, %s expected %0d actual %0d",
                     $time, words_checked, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        decode_result_t want;
        decode_result_t got;
        decode_result_t fresh;
        if (!aresetn) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                win[i] = '0;
            end
            clear_frame();
            {n_good, n_timing, n_length, n_header, n_crc} = '0;
            result_q.delete();
            fails = 0;
            fail_count    <= 0;
            outstanding   <= 0;
            words_checked <= 0;
            frames_good   <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                win[paddr[PADDR_W-1:2]] = pwdata[INTERVAL_W-1:0];
            end
            // results are checked before this edge's input is predicted
            if (m_tvalid && m_tready) begin
                got.ev     = event_t'(m_tdata[EV_W-1:0]);
                got.good   = m_tdata[EV_W +: COUNT_W];
                got.timing = m_tdata[EV_W + COUNT_W +: COUNT_W];
                got.length = m_tdata[EV_W + 2*COUNT_W +: COUNT_W];
                got.header = m_tdata[EV_W + 3*COUNT_W +: COUNT_W];
                got.crc    = m_tdata[EV_W + 4*COUNT_W +: COUNT_W];
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none actual event %0d",
                             $time, got.ev);
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    compare_field("event_res", COUNT_W'(want.ev), COUNT_W'(got.ev));
                    compare_field("frame_count", want.good, got.good);
                    compare_field("timing_errors", want.timing, got.timing);
                    compare_field("length_errors", want.length, got.length);
                    compare_field("header_errors", want.header, got.header);
                    compare_field("crc_errors", want.crc, got.crc);
                end
                words_checked <= words_checked + 1;
            end
            if (s_tvalid && s_tready) begin
                decode_edge(s_tdata[0], s_tdata[INTERVAL_W:1], fresh);
                result_q.push_back(fresh);
            end
            fail_count  <= fails;
            outstanding <= result_q.size();
            frames_good <= n_good;
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for pulse_width_frame_decoder_core: clock, reset, edge stimulus,
// receiver back-pressure, window register writes and the verdict.
// Depends on pwfd_pkg, the decoder RTL and pwfd_checker.
`timescale 1ns / 1ps

module tb_top;
    import pwfd_pkg::*;

    localparam int FRAME_BYTES   = 16;
    localparam int FRAME_BITS    = 8 * FRAME_BYTES;
    localparam int EDGE_TARGET   = 950;     // edge words in the random part
    localparam int STALL_LIMIT   = 2000;    // cycles without any word moving
    localparam int SETTLE_CYCLES = 3 * (FRAME_BYTES + 5);
    localparam int SET_COUNT     = 4;
    localparam logic [INTERVAL_W-1:0] IV_MAX = '1;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

    // window settings, in register order:
    // start min/max, stop min/max, zero min/max, one min/max
    localparam logic [INTERVAL_W-1:0] WINDOW_SETS [SET_COUNT][CFG_COUNT] = '{
        // disjoint windows, typical timing
        '{20'd9000, 20'd9999, 20'd5000, 20'd5999, 20'd500, 20'd700, 20'd1500, 20'd1800},
        // start at the top of the range, stop from zero, zero and one overlap
        '{20'd1048000, 20'hFFFFF, 20'd0, 20'd99, 20'd100, 20'd300, 20'd250, 20'd600},
        // stop overlaps start, so start wins on the shared part
        '{20'd2000, 20'd2999, 20'd2500, 20'd4000, 20'd10, 20'd20, 20'd21, 20'd40},
        // one window empty (min above max)
        '{20'd1, 20'd1, 20'd3, 20'd3, 20'd2, 20'd2, 20'hFFFFF, 20'd0}
    };

    // stimulus flavors for one frame attempt
    typedef enum int {
        FR_GOOD,    // well-formed frame with valid CRC
        FR_FLIP,    // one bit flipped somewhere in the frame
        FR_SHORT,   // fewer bits than a frame, then stop
        FR_LONG,    // more bits than a frame (store wraps), then stop
        FR_CUT,     // partial frame ended by a new start or a bad interval
        FR_NOISE    // a few arbitrary edges
    } frame_kind_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int outstanding;
    int words_checked;
    int frames_good;

    // sender/receiver pacing, reshuffled per frame attempt
    bit gap_en   = 1'b1;
    bit stall_en = 1'b1;
    int rx_hold  = 0;
    int quiet    = 0;

    logic [INTERVAL_W-1:0] cur_win [CFG_COUNT];
    logic [7:0]            tx_frame [FRAME_BYTES];
    int                    edges_sent   = 0;
    int                    frames_tried = 0;
    int                    sets_used    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pulse_width_frame_decoder_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),     // [0] level, [20:1] interval_us, [23:21] zero
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),     // [2:0] event, then frame/timing/length/header/crc counts
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pwfd_checker #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .words_checked(words_checked),
        .frames_good  (frames_good)
    );

    // Receiver: after each result word, draw a random hold when stalls are enabled
    // and keep m_tready low until it counts out; otherwise keep it high.
    always @(posedge aclk) begin : rx_side
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                hold = stall_en ? $urandom_range(0, 3) : 0;
            end else begin
                hold = (rx_hold > 0) ? rx_hold - 1 : 0;
            end
            rx_hold  <= hold;
            m_tready <= (hold == 0);
        end
    end

    // Watchdog: a long stretch with no word moving on either side is a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet == STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, outstanding);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [INTERVAL_W-1:0] rand_iv();
        return INTERVAL_W'($urandom_range(0, IV_MAX));
    endfunction

    // interval inside the window whose min sits at lo_idx; biased to the limits.
    // An empty window gives an arbitrary interval.
    function automatic logic [INTERVAL_W-1:0] pick_in(input logic [2:0] lo_idx);
        logic [INTERVAL_W-1:0] lo;
        logic [INTERVAL_W-1:0] hi;
        int r;
        lo = cur_win[lo_idx];
        hi = cur_win[lo_idx + 3'd1];
        r  = $urandom_range(0, 7);
        if (lo > hi) begin
            return rand_iv();
        end else if (r == 0) begin
            return lo;
        end else if (r == 1) begin
            return hi;
        end
        return INTERVAL_W'($urandom_range(hi, lo));
    endfunction

    // APB write: setup, access until pready, then idle
    task automatic reg_write(input logic [2:0] idx, input logic [INTERVAL_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // junk above bit 19 must be dropped by the register
        pwdata  <= {12'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic load_setting(input int set_idx);
        drain();
        for (int i = 0; i < CFG_COUNT; i++) begin
            reg_write(3'(i), WINDOW_SETS[set_idx][i]);
            cur_win[i] = WINDOW_SETS[set_idx][i];
        end
        sets_used++;
    endtask

    // one edge word; valid stays high across back-to-back words
    task automatic send_edge(input logic lvl, input logic [INTERVAL_W-1:0] iv);
        int gap;
        gap = gap_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {3'b000, iv, lvl};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        edges_sent++;
    endtask

    // header, random payload, CRC byte, trailer
    task automatic build_frame();
        logic [7:0] c;
        logic [7:0] d;
        tx_frame[0] = HEADER_CHAR;
        for (int i = 1; i < FRAME_BYTES - 2; i++) begin
            tx_frame[i] = 8'($urandom);
        end
        c = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 2; i++) begin
            d = tx_frame[i];
            for (int k = 0; k < 8; k++) begin
                c = (c[0] ^ d[0]) ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
                d = d >> 1;
            end
        end
        tx_frame[FRAME_BYTES-2] = c;
        tx_frame[FRAME_BYTES-1] = TRAILER_CHAR;
    endtask

    // data bits LSB first, wrapping over the frame; low edges sprinkled in
    task automatic send_bits(input int nbits);
        for (int n = 0; n < nbits; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_edge(1'b0, rand_iv());
            end
            if (tx_frame[(n / 8) % FRAME_BYTES][n % 8]) begin
                send_edge(1'b1, pick_in(CFG_ONE_MIN));
            end else begin
                send_edge(1'b1, pick_in(CFG_ZERO_MIN));
            end
        end
    endtask

    task automatic send_frame();
        frame_kind_t kind;
        int r;
        int nbits;
        int flip_byte;
        int flip_bit;
        r = $urandom_range(0, 9);
        kind = (r < 5) ? FR_GOOD : frame_kind_t'(r - 4);
        frames_tried++;
        // about one attempt in four runs without idling on a side
        gap_en   = ($urandom_range(0, 3) != 0);
        stall_en <= ($urandom_range(0, 3) != 0);
        build_frame();
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 6)) send_edge(1'($urandom), rand_iv());
            return;
        end
        send_edge(1'b1, pick_in(CFG_START_MIN));
        case (kind)
            FR_FLIP: begin
                flip_byte = $urandom_range(0, FRAME_BYTES - 1);
                flip_bit  = $urandom_range(0, 7);
                tx_frame[flip_byte][flip_bit] = ~tx_frame[flip_byte][flip_bit];
                nbits = FRAME_BITS;
            end
            FR_SHORT: nbits = $urandom_range(0, FRAME_BITS - 1);
            // a double frame wraps the store exactly and should still pass
            FR_LONG:  nbits = $urandom_range(0, 1) ? 2 * FRAME_BITS
                                                   : FRAME_BITS + $urandom_range(1, 23);
            FR_CUT:   nbits = $urandom_range(1, FRAME_BITS - 1);
            default:  nbits = FRAME_BITS;
        endcase
        send_bits(nbits);
        if (kind == FR_CUT) begin
            send_edge(1'b1, $urandom_range(0, 1) ? pick_in(CFG_START_MIN) : rand_iv());
        end else begin
            send_edge(1'b1, pick_in(CFG_STOP_MIN));
        end
    endtask

    initial begin : stimulus
        int base;
        int set_now;
        int cur_set;
        for (int i = 0; i < CFG_COUNT; i++) begin
            cur_win[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset windows: every window is [0,0], so start wins on 0.
        send_edge(1'b1, '0);            // start
        send_edge(1'b1, '0);            // start with nothing pending
        send_edge(1'b1, 20'd1);         // in frame, no window: timing error
        send_edge(1'b1, IV_MAX);        // outside a frame: ignored
        send_edge(1'b0, '0);            // low level: ignored

        // Directed, disjoint windows, window limits hit exactly.
        load_setting(0);
        send_edge(1'b0, IV_MAX);
        send_edge(1'b1, cur_win[CFG_ZERO_MAX]);     // outside a frame
        send_edge(1'b1, cur_win[CFG_START_MIN]);
        send_edge(1'b1, cur_win[CFG_ZERO_MIN]);
        send_edge(1'b1, cur_win[CFG_ONE_MAX]);
        send_edge(1'b1, cur_win[CFG_START_MAX]);    // start with bits pending
        send_edge(1'b1, cur_win[CFG_ZERO_MAX]);
        send_edge(1'b1, cur_win[CFG_ONE_MIN]);
        send_edge(1'b1, cur_win[CFG_STOP_MIN]);     // stop mid-byte, byte count zero: header error
        send_edge(1'b1, cur_win[CFG_START_MIN]);
        send_edge(1'b1, cur_win[CFG_STOP_MAX]);     // empty store: header error
        send_edge(1'b1, cur_win[CFG_START_MIN]);
        send_edge(1'b1, cur_win[CFG_ONE_MIN]);
        send_edge(1'b1, IV_MAX);                    // timing error ends the frame
        send_edge(1'b1, '0);                        // ignored again
        cur_set = 0;

        // Random part: frame-shaped sequences, walking through the settings.
        base = edges_sent;
        while (edges_sent - base < EDGE_TARGET) begin
            set_now = (edges_sent - base < 400) ? 0 :
                      (edges_sent - base < 650) ? 1 :
                      (edges_sent - base < 850) ? 2 : 3;
            if (set_now != cur_set) begin
                load_setting(set_now);
                cur_set = set_now;
            end
            send_frame();
            // now and then let the pipe run dry before the next frame
            if ($urandom_range(0, 7) == 0) begin
                drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d edge words in %0d frame attempts over %0d settings",
                 edges_sent, frames_tried, sets_used);
        $display("Checked %0d result words, %0d frames decoded good", words_checked,
                 frames_good);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
